// File: rtl/cimpm_pkg.sv
// Package for the case-insensitive multi-pattern match unit.
// Holds default sizes, input mode codes, the sequencer state type and the lowercase helper.
// No dependencies.
`default_nettype none
package cimpm_pkg;

  localparam int unsigned NumPatternsDef = 16;
  localparam int unsigned MaxLenDef      = 32;

  localparam logic [1:0] ModeClear   = 2'd0;
  localparam logic [1:0] ModePattern = 2'd1;
  localparam logic [1:0] ModeBody    = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StRdLen,
    StGetLen,
    StCmp,
    StFin
  } state_e;

  // Only 'A'..'Z' are folded; every other byte passes unchanged.
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cimpm_if.sv
// Valid/ready channel interfaces for the match unit: input items and result items.
// Depends on nothing.
`default_nettype none
interface cimpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, mode, data_byte, last, input ready);
  modport sink (input valid, mode, data_byte, last, output ready);
endinterface

interface cimpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic patterns_dropped;
  modport source (output valid, matched, patterns_dropped, input ready);
  modport sink (input valid, matched, patterns_dropped, output ready);
endinterface
`default_nettype wire

// File: rtl/cimpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module cimpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/cimpm_hist_cell.sv
// One cell of the body history chain: holds one byte and passes it to its neighbor on a shift.
// No dependencies.
`default_nettype none
module cimpm_hist_cell (
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] data_i,
  output logic      [7:0] data_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= data_i;
    end
  end

  assign data_o = byte_q;

endmodule
`default_nettype wire

// File: rtl/case_insensitive_multi_pattern_match_unit.sv
// Top level of the case-insensitive multi-pattern match unit.
// Depends on cimpm_pkg, cimpm_if, cimpm_ram and cimpm_hist_cell.
`default_nettype none
// The unit holds up to NUM_PATTERNS lowercase patterns of up to MAX_LEN bytes
// and reports, once per body, whether the body contains any of them, ignoring
// ASCII case. Clear and pattern items leave the unit idle. A body item enters
// the history chain and then starts a scan over the stored patterns: for each
// pattern, its length is fetched in StRdLen and StGetLen and its bytes are
// compared in StCmp, since the pattern memory has a single read port and one
// byte is read each cycle. The scan stops at the first hit and is skipped when
// the body already hit or no pattern is stored; no item is taken during it.
// The final byte of a body yields one result item, which waits in an output
// register while the next item is taken.
module case_insensitive_multi_pattern_match_unit #(
  parameter int unsigned NUM_PATTERNS = cimpm_pkg::NumPatternsDef,
  parameter int unsigned MAX_LEN      = cimpm_pkg::MaxLenDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cimpm_in_if.sink    in_i,
  cimpm_out_if.source out_o
);

  localparam int unsigned CW   = $clog2(NUM_PATTERNS + 1);
  localparam int unsigned PW   = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int unsigned LW   = $clog2(MAX_LEN + 1);
  localparam int unsigned IW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned DEP  = NUM_PATTERNS * MAX_LEN;
  localparam int unsigned AW   = (DEP > 1) ? $clog2(DEP) : 1;
  localparam logic [AW-1:0] MaxLenA = AW'(MAX_LEN);
  localparam logic [LW-1:0] MaxLenL = LW'(MAX_LEN);
  localparam logic [CW-1:0] NumPatC = CW'(NUM_PATTERNS);

  cimpm_pkg::state_e state_q, state_d;

  // Table and loading state.
  logic [CW-1:0] count_q;
  logic [LW-1:0] pos_q;
  logic          ovl_q;
  logic          drop_q;
  // Body state.
  logic [LW-1:0] seen_q;
  logic          hit_q;
  logic          last_q;
  // Scan state.
  logic [PW-1:0] p_q;
  logic [IW-1:0] k_q;
  logic [LW-1:0] len_q;
  // Output register.
  logic out_valid_q, matched_q, dropped_q;

  logic [7:0] c_low;
  logic       accept;
  assign in_i.ready = (state_q == cimpm_pkg::StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign c_low      = cimpm_pkg::to_lower(in_i.data_byte);

  logic acc_clear, acc_pat, acc_body;
  assign acc_clear = accept && (in_i.mode == cimpm_pkg::ModeClear);
  assign acc_pat   = accept && (in_i.mode == cimpm_pkg::ModePattern);
  assign acc_body  = accept && (in_i.mode == cimpm_pkg::ModeBody);

  // History chain: cell 0 holds the newest body byte.
  logic [7:0] hist [MAX_LEN];
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_hist
    logic [7:0] cell_in;
    if (i == 0) begin : g_head
      assign cell_in = c_low;
    end else begin : g_link
      assign cell_in = hist[i-1];
    end
    cimpm_hist_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(acc_body),
      .data_i (cell_in),
      .data_o (hist[i])
    );
  end

  // Pattern byte loading: store while the pattern fits and the table has room.
  logic          pat_fits, table_room, pat_ovl_n, pat_commit, pat_drop;
  logic [LW-1:0] pos_inc;
  assign pat_fits   = pos_q < MaxLenL;
  assign table_room = count_q < NumPatC;
  assign pos_inc    = pat_fits ? pos_q + LW'(1) : pos_q;
  assign pat_ovl_n  = ovl_q || !pat_fits;
  assign pat_commit = acc_pat && in_i.last && !pat_ovl_n && table_room;
  assign pat_drop   = acc_pat && in_i.last && !(!pat_ovl_n && table_room);

  logic          byte_we;
  logic [AW-1:0] byte_waddr, byte_raddr;
  logic [7:0]    byte_rdata;
  logic [LW-1:0] len_rdata;
  assign byte_we    = acc_pat && pat_fits && table_room;
  assign byte_waddr = AW'(count_q) * MaxLenA + AW'(pos_q);

  // Scan comparisons.
  logic          p_is_last, too_long, eq, k_end;
  logic [LW-1:0] hidx_full;
  logic [IW-1:0] hidx;
  assign p_is_last = (CW'(p_q) + CW'(1)) == count_q;
  assign too_long  = len_rdata > seen_q;
  assign hidx_full = len_q - LW'(1) - LW'(k_q);
  assign hidx      = hidx_full[IW-1:0];
  assign eq        = byte_rdata == hist[hidx];
  assign k_end     = (LW'(k_q) + LW'(1)) == len_q;

  logic out_free;
  assign out_free = !out_valid_q || out_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cimpm_pkg::StIdle: begin
        if (acc_body) begin
          state_d = (hit_q || count_q == '0) ? cimpm_pkg::StFin : cimpm_pkg::StRdLen;
        end
      end
      cimpm_pkg::StRdLen: state_d = cimpm_pkg::StGetLen;
      cimpm_pkg::StGetLen: begin
        if (too_long) begin
          state_d = p_is_last ? cimpm_pkg::StFin : cimpm_pkg::StRdLen;
        end else begin
          state_d = cimpm_pkg::StCmp;
        end
      end
      cimpm_pkg::StCmp: begin
        if (!eq) begin
          state_d = p_is_last ? cimpm_pkg::StFin : cimpm_pkg::StRdLen;
        end else if (k_end) begin
          state_d = cimpm_pkg::StFin;
        end
      end
      cimpm_pkg::StFin: begin
        if (!last_q || out_free) begin
          state_d = cimpm_pkg::StIdle;
        end
      end
      default: state_d = cimpm_pkg::StIdle;
    endcase
  end

  // Sequencer outputs.
  logic next_pat, scan_hit, emit;
  always_comb begin
    next_pat   = 1'b0;
    scan_hit   = 1'b0;
    emit       = 1'b0;
    byte_raddr = AW'(p_q) * MaxLenA;
    case (state_q)
      cimpm_pkg::StGetLen: next_pat = too_long;
      cimpm_pkg::StCmp: begin
        next_pat   = !eq;
        scan_hit   = eq && k_end;
        byte_raddr = AW'(p_q) * MaxLenA + AW'(k_q) + AW'(1);
      end
      cimpm_pkg::StFin: emit = last_q && out_free;
      default: ;
    endcase
  end

  cimpm_ram #(.WIDTH(8), .DEPTH(DEP)) u_bytes (
    .clk_i  (clk_i),
    .we_i   (byte_we),
    .waddr_i(byte_waddr),
    .wdata_i(c_low),
    .raddr_i(byte_raddr),
    .rdata_o(byte_rdata)
  );

  cimpm_ram #(.WIDTH(LW), .DEPTH(NUM_PATTERNS)) u_lens (
    .clk_i  (clk_i),
    .we_i   (pat_commit),
    .waddr_i(count_q[PW-1:0]),
    .wdata_i(pos_inc),
    .raddr_i(p_q),
    .rdata_o(len_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cimpm_pkg::StIdle;
      count_q     <= '0;
      pos_q       <= '0;
      ovl_q       <= 1'b0;
      drop_q      <= 1'b0;
      seen_q      <= '0;
      hit_q       <= 1'b0;
      last_q      <= 1'b0;
      p_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc_clear) begin
        count_q <= '0;
        pos_q   <= '0;
        ovl_q   <= 1'b0;
        drop_q  <= 1'b0;
        seen_q  <= '0;
        hit_q   <= 1'b0;
      end
      if (acc_pat) begin
        if (in_i.last) begin
          pos_q <= '0;
          ovl_q <= 1'b0;
        end else begin
          pos_q <= pos_inc;
          ovl_q <= pat_ovl_n;
        end
        if (pat_commit) begin
          count_q <= count_q + CW'(1);
        end
        if (pat_drop) begin
          drop_q <= 1'b1;
        end
      end
      if (acc_body) begin
        if (seen_q < MaxLenL) begin
          seen_q <= seen_q + LW'(1);
        end
        last_q <= in_i.last;
        p_q    <= '0;
      end
      if (state_q == cimpm_pkg::StGetLen) begin
        k_q <= '0;
      end else if (state_q == cimpm_pkg::StCmp) begin
        k_q <= k_q + IW'(1);
      end
      if (next_pat) begin
        p_q <= p_q + PW'(1);
      end
      if (scan_hit) begin
        hit_q <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        seen_q      <= '0;
        hit_q       <= 1'b0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cimpm_pkg::StGetLen) begin
      len_q <= len_rdata;
    end
    if (emit) begin
      matched_q <= hit_q;
      dropped_q <= drop_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.matched          = matched_q;
  assign out_o.patterns_dropped = dropped_q;

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the case-insensitive multi-pattern match unit.
// Depends on cimpm_pkg, cimpm_if and the unit's RTL; predicts results internally.
`timescale 1ns / 100ps
module tb_top;

  localparam int NP = cimpm_pkg::NumPatternsDef;
  localparam int ML = cimpm_pkg::MaxLenDef;
  localparam int CycleLimit = 3000000;
  // Mode code that the unit ignores.
  localparam logic [1:0] ModeUnused = 2'd3;

  // One input item as the driver presents it.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last;
  } match_item_t;

  // One predicted result item.
  typedef struct packed {
    logic matched;
    logic patterns_dropped;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  cimpm_in_if  in_ch ();
  cimpm_out_if out_ch ();

  case_insensitive_multi_pattern_match_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Predictor state: the stored table, the pattern being loaded and the body history.
  logic [7:0] tbl_bytes [NP][ML];
  int         tbl_len [NP];
  int         tbl_count;
  int         load_pos;
  bit         load_long;
  bit         dropped_any;
  logic [7:0] hist [ML];
  int         hist_seen;
  bit         body_hit;

  match_item_t pending_items[$];
  verdict_t    expected_verdicts[$];
  int          errors;
  int          cycles;
  int          items_sent;
  int          verdicts_seen;
  bit          hold_sender;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void predictor_clear_body();
    for (int i = 0; i < ML; i++) hist[i] = 8'd0;
    hist_seen = 0;
    body_hit  = 1'b0;
  endfunction

  function automatic void predictor_clear_table();
    for (int p = 0; p < NP; p++) tbl_len[p] = 0;
    tbl_count   = 0;
    load_pos    = 0;
    load_long   = 1'b0;
    dropped_any = 1'b0;
  endfunction

  function automatic bit any_suffix_hit();
    bit eq;
    for (int p = 0; p < tbl_count; p++) begin
      if (tbl_len[p] == 0 || tbl_len[p] > hist_seen) continue;
      eq = 1'b1;
      for (int k = 0; k < tbl_len[p]; k++) begin
        if (tbl_bytes[p][k] != hist[tbl_len[p] - 1 - k]) eq = 1'b0;
      end
      if (eq) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the predictor by one accepted item and queues any verdict it causes.
  function automatic void predict_match(input match_item_t it);
    logic [7:0] c;
    verdict_t v;
    c = fold_case(it.data_byte);
    case (it.mode)
      cimpm_pkg::ModeClear: begin
        predictor_clear_table();
        predictor_clear_body();
      end
      cimpm_pkg::ModePattern: begin
        if (load_pos < ML) begin
          if (tbl_count < NP) tbl_bytes[tbl_count][load_pos] = c;
          load_pos++;
        end else begin
          load_long = 1'b1;
        end
        if (it.last) begin
          // Overlong patterns and patterns arriving on a full table are dropped.
          if (load_long || tbl_count >= NP) begin
            dropped_any = 1'b1;
          end else begin
            tbl_len[tbl_count] = load_pos;
            tbl_count++;
          end
          load_pos  = 0;
          load_long = 1'b0;
        end
      end
      cimpm_pkg::ModeBody: begin
        for (int i = ML - 1; i > 0; i--) hist[i] = hist[i - 1];
        hist[0] = c;
        if (hist_seen < ML) hist_seen++;
        if (any_suffix_hit()) body_hit = 1'b1;
        if (it.last) begin
          v.matched          = body_hit;
          v.patterns_dropped = dropped_any;
          expected_verdicts = {expected_verdicts, v};
          predictor_clear_body();
        end
      end
      default: ;  // Mode 3 is ignored by the unit.
    endcase
  endfunction

  // Random byte, often a letter in either case so that matches actually occur.
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'("a") + 8'($urandom_range(0, 3));
    if (r < 7) return 8'("A") + 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_item(input logic [1:0] m, input logic [7:0] b, input logic l);
    match_item_t it;
    it.mode = m;
    it.data_byte = b;
    it.last = l;
    pending_items = {pending_items, it};
  endtask

  task automatic push_pattern(input int len);
    for (int i = 0; i < len; i++) push_item(cimpm_pkg::ModePattern, rand_byte(), i == len - 1);
  endtask

  task automatic push_body(input int len);
    for (int i = 0; i < len; i++) push_item(cimpm_pkg::ModeBody, rand_byte(), i == len - 1);
  endtask

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Driver: takes items from the pending queue with a random gap after each one.
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.mode      <= cimpm_pkg::ModeClear;
      in_ch.data_byte <= 8'd0;
      in_ch.last      <= 1'b0;
      gap_left        <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_match('{in_ch.mode, in_ch.data_byte, in_ch.last});
        items_sent++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the current item until it is taken.
      end else if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (pending_items.size() != 0 && !hold_sender) begin
        match_item_t it;
        it = pending_items.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= it.mode;
        in_ch.data_byte <= it.data_byte;
        in_ch.last      <= it.last;
        gap_left        <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: random stalls on the result side, compare against the oldest verdict.
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        verdict_t exp_v;
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          $error("result item with nothing expected: matched=%0d dropped=%0d",
                 out_ch.matched, out_ch.patterns_dropped);
          errors++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (out_ch.matched !== exp_v.matched) begin
            $error("matched: expected %0d, got %0d", exp_v.matched, out_ch.matched);
            errors++;
          end
          if (out_ch.patterns_dropped !== exp_v.patterns_dropped) begin
            $error("patterns_dropped: expected %0d, got %0d",
                   exp_v.patterns_dropped, out_ch.patterns_dropped);
            errors++;
          end
        end
        stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    items_sent = 0;
    verdicts_seen = 0;
    hold_sender = 1'b0;
    predictor_clear_table();
    predictor_clear_body();
    for (int p = 0; p < NP; p++)
      for (int k = 0; k < ML; k++) tbl_bytes[p][k] = 8'd0;

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: case folding, an overlong pattern, the ignored mode,
    // a clear and a one-byte body.
    push_item(cimpm_pkg::ModePattern, "A", 1'b0);
    push_item(cimpm_pkg::ModePattern, "z", 1'b1);
    push_item(cimpm_pkg::ModeBody, "x", 1'b0);
    push_item(cimpm_pkg::ModeBody, "a", 1'b0);
    push_item(cimpm_pkg::ModeBody, "Z", 1'b1);      // hit with mixed case
    push_item(cimpm_pkg::ModeBody, 8'hff, 1'b1);    // one-byte body, high byte
    push_item(ModeUnused, 8'h5a, 1'b1);             // unused mode
    for (int i = 0; i < ML + 1; i++) push_item(cimpm_pkg::ModePattern, 8'h00, i == ML);
    push_item(cimpm_pkg::ModeBody, 8'h00, 1'b1);    // reports drop
    push_item(cimpm_pkg::ModeClear, 8'hff, 1'b1);
    push_item(cimpm_pkg::ModePattern, "@", 1'b1);   // just below 'A'
    push_item(cimpm_pkg::ModePattern, "[", 1'b1);   // just above 'Z'
    push_item(cimpm_pkg::ModeBody, "[", 1'b1);

    // Random part: mostly well-formed table loads and bodies, occasional
    // clears, overfills and stray items. A pause drains the unit once.
    while (pending_items.size() + items_sent < 700) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) push_item(cimpm_pkg::ModeClear, rand_byte(), 1'($urandom_range(0, 1)));
      else if (r < 5) push_item(ModeUnused, rand_byte(), 1'($urandom_range(0, 1)));
      else if (r < 35) push_pattern($urandom_range(0, 9) == 0 ? $urandom_range(1, ML + 3)
                                                          : $urandom_range(1, 3));
      else if (r < 40) begin
        for (int i = 0; i < NP + 1; i++) push_pattern(1);    // fill past capacity
      end else push_body($urandom_range(0, 7) == 0 ? $urandom_range(1, 60)
                                                 : $urandom_range(1, 8));
      if (items_sent == 0 && pending_items.size() > 300 && !hold_sender) begin
        // Drain everything queued so far before the rest.
        wait (pending_items.size() == 0);
        wait (!in_ch.valid);
        hold_sender = 1'b1;
        wait (expected_verdicts.size() == 0);
        hold_sender = 1'b0;
      end
    end

    wait (pending_items.size() == 0 && !in_ch.valid);
    wait (expected_verdicts.size() == 0);
    repeat (NP * (ML + 2) + 20) @(posedge clk_i);

    $display("Sent %0d items and checked %0d body verdicts against the predictor.",
             items_sent, verdicts_seen);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cimpm_pkg.sv
rtl/cimpm_if.sv
rtl/cimpm_ram.sv
rtl/cimpm_hist_cell.sv
rtl/case_insensitive_multi_pattern_match_unit.sv
test/tb_top.sv
